>>> rtl/dcf_pkg.sv
// shared types, constants and the command length table for the display command framer
`timescale 1ns / 1ps

package dcf_pkg;

  localparam int DCF_MAX_CMD_WORDS = 22;
  localparam int DCF_WORD_W        = 64;
  localparam int DCF_OPC_W         = 6;
  localparam int DCF_LEN_W         = 5;
  localparam int DCF_OPC_HI        = 61;
  localparam int DCF_OPC_LO        = 56;
  localparam logic [DCF_OPC_W-1:0] DCF_MIN_FWD_OPCODE = 6'd8;
  localparam logic [DCF_OPC_W-1:0] DCF_SYNC_OPCODE_RST = 6'd41;

  // register map
  localparam int DCF_PADDR_W = 3;
  localparam logic DCF_REG_SYNC_OPCODE = 1'b0;

  localparam logic DCF_KIND_WORD   = 1'b0;
  localparam logic DCF_KIND_STATUS = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WORDS,
    ST_SYNC0,
    ST_STATUS
  } dcf_state_t;

  typedef struct packed {
    logic                  kind;
    logic [DCF_WORD_W-1:0] word;
    logic                  last;
    logic                  sync;
    logic                  ready;
    logic                  busy;
  } dcf_result_t;

  // command length in words, by opcode
  function automatic logic [DCF_LEN_W-1:0] dcf_cmd_len(input logic [DCF_OPC_W-1:0] opc);
    logic [DCF_LEN_W-1:0] len;
    unique case (opc)
      6'd8:  len = 5'd4;
      6'd9:  len = 5'd6;
      6'd10: len = 5'd12;
      6'd11: len = 5'd14;
      6'd12: len = 5'd12;
      6'd13: len = 5'd14;
      6'd14: len = 5'd20;
      6'd15: len = 5'd22;
      6'd36: len = 5'd2;
      6'd37: len = 5'd2;
      default: len = 5'd1;
    endcase
    return len;
  endfunction

endpackage

>>> rtl/dcf_word_store.sv
// command word memory, one write port and one registered read port
`timescale 1ns / 1ps

module dcf_word_store
  import dcf_pkg::*;
#(
  parameter int MAX_CMD_WORDS = DCF_MAX_CMD_WORDS,
  parameter int AW            = $clog2(MAX_CMD_WORDS)
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  logic [DCF_WORD_W-1:0] wr_data,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output logic [DCF_WORD_W-1:0] rd_data
);

  logic [DCF_WORD_W-1:0] mem [MAX_CMD_WORDS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/dcf_framer.sv
// framing control: counters, read sequencer and result register
`timescale 1ns / 1ps

module dcf_framer
  import dcf_pkg::*;
#(
  parameter int MAX_CMD_WORDS = DCF_MAX_CMD_WORDS,
  parameter int AW            = $clog2(MAX_CMD_WORDS),
  parameter int CW            = $clog2(MAX_CMD_WORDS + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [DCF_OPC_W-1:0]  sync_opcode,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [DCF_WORD_W-1:0] cmd_word,
  input  logic                  end_of_batch,
  output logic                  mem_wr_en,
  output logic [AW-1:0]         mem_wr_addr,
  output logic                  mem_rd_en,
  output logic [AW-1:0]         mem_rd_addr,
  input  logic [DCF_WORD_W-1:0] mem_rd_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output dcf_result_t           result
);

  dcf_state_t state, state_next;

  logic [CW-1:0]        held, held_next;
  logic [DCF_LEN_W-1:0] needed, needed_next;
  logic [DCF_OPC_W-1:0] first_opc, first_opc_next;
  logic                 busy, busy_next;
  logic                 batch_open, batch_open_next;
  logic                 step_eob, step_eob_next;
  logic                 step_sync, step_sync_next;
  logic                 step_ready, step_ready_next;
  logic [CW-1:0]        emit_cnt, emit_cnt_next;
  logic [CW-1:0]        rd_idx, rd_idx_next;
  logic [CW-1:0]        ld_idx, ld_idx_next;
  logic                 rd_pending, rd_pending_next;
  logic                 out_valid_next;
  dcf_result_t          result_next;

  // accept-time datapath
  logic                 accept;
  logic                 busy_a;
  logic [CW-1:0]        held_g;
  logic [CW-1:0]        held_inc;
  logic [DCF_OPC_W-1:0] opc_w;
  logic [DCF_OPC_W-1:0] opc_f;
  logic [DCF_LEN_W-1:0] need_a;
  logic                 done;
  logic                 is_sync;
  logic                 out_free;
  logic                 load;
  logic                 issue;
  logic [CW-1:0]        ld_idx_inc;

  assign in_stall    = (state != ST_IDLE);
  assign accept      = in_valid && !in_stall;
  assign busy_a      = batch_open ? busy : 1'b1;
  assign held_g      = (held >= CW'(MAX_CMD_WORDS)) ? '0 : held;
  assign held_inc    = held_g + CW'(1);
  assign opc_w       = cmd_word[DCF_OPC_HI:DCF_OPC_LO];
  assign opc_f       = (held_g == '0) ? opc_w : first_opc;
  assign need_a      = (held_g == '0) ? dcf_cmd_len(opc_w) : needed;
  assign done        = (held_inc >= CW'(need_a));
  assign is_sync     = (opc_f == sync_opcode);

  assign mem_wr_en   = accept;
  assign mem_wr_addr = held_g[AW-1:0];

  assign out_free    = !out_valid || !out_stall;
  assign load        = (state == ST_WORDS) && rd_pending && out_free;
  assign issue       = (state == ST_WORDS) && (rd_idx < emit_cnt) && (!rd_pending || load);
  assign ld_idx_inc  = ld_idx + CW'(1);
  assign mem_rd_en   = issue;
  assign mem_rd_addr = rd_idx[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      held       <= '0;
      needed     <= '0;
      busy       <= 1'b0;
      batch_open <= 1'b0;
      rd_pending <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      held       <= held_next;
      needed     <= needed_next;
      busy       <= busy_next;
      batch_open <= batch_open_next;
      rd_pending <= rd_pending_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    first_opc  <= first_opc_next;
    step_eob   <= step_eob_next;
    step_sync  <= step_sync_next;
    step_ready <= step_ready_next;
    emit_cnt   <= emit_cnt_next;
    rd_idx     <= rd_idx_next;
    ld_idx     <= ld_idx_next;
    result     <= result_next;
  end

  always_comb begin
    state_next      = state;
    held_next       = held;
    needed_next     = needed;
    first_opc_next  = first_opc;
    busy_next       = busy;
    batch_open_next = batch_open;
    step_eob_next   = step_eob;
    step_sync_next  = step_sync;
    step_ready_next = step_ready;
    emit_cnt_next   = emit_cnt;
    rd_idx_next     = issue ? rd_idx + CW'(1) : rd_idx;
    ld_idx_next     = load ? ld_idx_inc : ld_idx;
    rd_pending_next = issue ? 1'b1 : (load ? 1'b0 : rd_pending);
    out_valid_next  = out_valid && out_stall;
    result_next     = result;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          batch_open_next = !end_of_batch;
          step_eob_next   = end_of_batch;
          step_sync_next  = is_sync;
          step_ready_next = done;
          emit_cnt_next   = held_inc;
          rd_idx_next     = '0;
          ld_idx_next     = '0;
          rd_pending_next = 1'b0;
          if (done) begin
            held_next   = '0;
            needed_next = '0;
            busy_next   = is_sync ? 1'b0 : busy_a;
            if (opc_f >= DCF_MIN_FWD_OPCODE) begin
              state_next = ST_WORDS;
            end else if (is_sync) begin
              state_next = ST_SYNC0;
            end else if (end_of_batch) begin
              state_next = ST_STATUS;
            end
          end else begin
            held_next      = held_inc;
            needed_next    = need_a;
            first_opc_next = opc_f;
            busy_next      = busy_a;
            if (end_of_batch) begin
              state_next = ST_STATUS;
            end
          end
        end
      end
      ST_WORDS: begin
        if (load) begin
          out_valid_next     = 1'b1;
          result_next.kind   = DCF_KIND_WORD;
          result_next.word   = mem_rd_data;
          result_next.sync   = step_sync;
          result_next.ready  = 1'b0;
          result_next.busy   = busy;
          result_next.last   = (ld_idx_inc == emit_cnt) && !step_eob;
          if (ld_idx_inc == emit_cnt) begin
            state_next = step_eob ? ST_STATUS : ST_IDLE;
          end
        end
      end
      ST_SYNC0: begin
        if (out_free) begin
          out_valid_next    = 1'b1;
          result_next.kind  = DCF_KIND_WORD;
          result_next.word  = '0;
          result_next.sync  = 1'b1;
          result_next.ready = 1'b0;
          result_next.busy  = busy;
          result_next.last  = !step_eob;
          state_next        = step_eob ? ST_STATUS : ST_IDLE;
        end
      end
      ST_STATUS: begin
        if (out_free) begin
          out_valid_next    = 1'b1;
          result_next.kind  = DCF_KIND_STATUS;
          result_next.word  = '0;
          result_next.sync  = 1'b0;
          result_next.ready = step_ready;
          result_next.busy  = busy;
          result_next.last  = 1'b1;
          state_next        = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/display_command_framer_core.sv
// top level of the display command framer: register port, word memory and framing control
`timescale 1ns / 1ps

// Display command framer. Accepts one 64-bit command word per input transaction,
// stores it in an on-chip word memory and, once the opcode in bits 61..56 of a
// command's first word says the command is complete, replays the command's words
// from memory as a run of output transactions (opcodes below 8 are dropped; the
// sync opcode sets sync_interrupt on its words and clears pipe_busy). A word
// marked end_of_batch adds one status transaction (buffer_ready = nothing held).
// last_of_run marks the final output transaction caused by an input. A forwarded
// command's words are read from the memory, whose read port is registered, and
// pass through the output register one word per cycle while out_stall is low.
// The output register lets the next input be accepted while the last result
// still waits. sync_opcode resets to 41 and lies at byte address 0 of the
// register port; write it only while the block is idle.

module display_command_framer_core
  import dcf_pkg::*;
#(
  parameter int MAX_CMD_WORDS = DCF_MAX_CMD_WORDS
) (
  input  logic                   clk,
  input  logic                   rst,
  // register port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [DCF_PADDR_W-1:0] paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  // input channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [DCF_WORD_W-1:0]  cmd_word,
  input  logic                   end_of_batch,
  // output channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   kind,
  output logic [DCF_WORD_W-1:0]  out_word,
  output logic                   last_of_run,
  output logic                   sync_interrupt,
  output logic                   buffer_ready,
  output logic                   pipe_busy
);

  localparam int AW = $clog2(MAX_CMD_WORDS);
  localparam int CW = $clog2(MAX_CMD_WORDS + 1);

  logic [DCF_OPC_W-1:0]  sync_opcode;
  logic                  reg_wr;
  logic                  sel_sync;

  logic                  mem_wr_en;
  logic [AW-1:0]         mem_wr_addr;
  logic                  mem_rd_en;
  logic [AW-1:0]         mem_rd_addr;
  logic [DCF_WORD_W-1:0] mem_rd_data;
  dcf_result_t           result;

  // register port, zero wait states
  assign pready   = 1'b1;
  assign sel_sync = (paddr[2] == DCF_REG_SYNC_OPCODE);
  assign reg_wr   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_opcode <= DCF_SYNC_OPCODE_RST;
    end else if (reg_wr && sel_sync) begin
      sync_opcode <= pwdata[DCF_OPC_W-1:0];
    end
  end

  // read data is zero wherever paddr[2] is set
  assign prdata = sel_sync ? {{(32 - DCF_OPC_W){1'b0}}, sync_opcode} : '0;

  // words of the command being collected
  dcf_word_store #(
    .MAX_CMD_WORDS (MAX_CMD_WORDS),
    .AW            (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (cmd_word),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // length lookup, counters, replay sequencer and output register
  dcf_framer #(
    .MAX_CMD_WORDS (MAX_CMD_WORDS),
    .AW            (AW),
    .CW            (CW)
  ) u_framer (
    .clk          (clk),
    .rst          (rst),
    .sync_opcode  (sync_opcode),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd_word     (cmd_word),
    .end_of_batch (end_of_batch),
    .mem_wr_en    (mem_wr_en),
    .mem_wr_addr  (mem_wr_addr),
    .mem_rd_en    (mem_rd_en),
    .mem_rd_addr  (mem_rd_addr),
    .mem_rd_data  (mem_rd_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result       (result)
  );

  assign kind           = result.kind;
  assign out_word       = result.word;
  assign last_of_run    = result.last;
  assign sync_interrupt = result.sync;
  assign buffer_ready   = result.ready;
  assign pipe_busy      = result.busy;

endmodule

>>> verif/display_command_framer_core_tb.sv
// self-checking testbench for the display command framer core
`timescale 1ns / 1ps

module display_command_framer_core_tb
  import dcf_pkg::*;
();

  // register map: sync_opcode is register 0, byte address 0
  localparam logic [DCF_PADDR_W-1:0] SYNC_OPCODE_ADDR = DCF_PADDR_W'(4 * DCF_REG_SYNC_OPCODE);
  // cycles allowed after the last expected result before the block counts as idle
  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_PRINTED_ERRORS = 40;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [DCF_PADDR_W-1:0] paddr;
  logic [31:0]            pwdata;
  logic [31:0]            prdata;
  logic                   pready;
  logic                   in_valid;
  logic                   in_stall;
  logic [DCF_WORD_W-1:0]  cmd_word;
  logic                   end_of_batch;
  logic                   out_valid;
  logic                   out_stall;
  logic                   kind;
  logic [DCF_WORD_W-1:0]  out_word;
  logic                   last_of_run;
  logic                   sync_interrupt;
  logic                   buffer_ready;
  logic                   pipe_busy;

  display_command_framer_core uut (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .cmd_word       (cmd_word),
    .end_of_batch   (end_of_batch),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .out_word       (out_word),
    .last_of_run    (last_of_run),
    .sync_interrupt (sync_interrupt),
    .buffer_ready   (buffer_ready),
    .pipe_busy      (pipe_busy)
  );

  always #4 clk = ~clk;

  // framer state as the testbench sees it
  logic [4:0]            cmd_words_of [0:63];
  logic [DCF_WORD_W-1:0] held_words [0:DCF_MAX_CMD_WORDS-1];
  int                    held_n;
  int                    need_len;
  logic                  busy_flag;
  logic                  batch_open;
  logic [DCF_OPC_W-1:0]  sync_opc;

  // results still owed by the block, oldest first
  dcf_result_t expected_results [$];

  // idling controls shared by the sender, receiver and tests
  bit tx_idle_on;
  bit rx_idle_on;
  int rx_wait;
  int long_hold;

  int error_count;
  int words_sent;
  int results_seen;
  int cmds_forwarded;
  int sync_cmds;
  int status_count;
  int sync_writes;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    error_count++;
    if (error_count <= MAX_PRINTED_ERRORS)
      $display("%0t ns mismatch on %s: got %h, want %h", $time, what, got, want);
  endtask

  // first word of a command: opcode sits in bits 61..56
  function automatic logic [63:0] with_opcode(input logic [63:0] body,
                                              input logic [DCF_OPC_W-1:0] opc);
    logic [63:0] w;
    w = body;
    w[DCF_OPC_HI:DCF_OPC_LO] = opc;
    return w;
  endfunction

  function automatic logic [63:0] random_word();
    return {$urandom, $urandom};
  endfunction

  // advance the framer state by one accepted word and queue what it must produce
  task automatic frame_word(input logic [63:0] word, input logic eob);
    dcf_result_t run [$];
    dcf_result_t r;
    logic [DCF_OPC_W-1:0] opc;
    logic is_sync;
    // first word of a batch marks the pipe busy before framing
    if (!batch_open) begin
      busy_flag = 1'b1;
      batch_open = 1'b1;
    end
    if (held_n >= DCF_MAX_CMD_WORDS) held_n = 0;
    if (held_n == 0) need_len = int'(cmd_words_of[word[DCF_OPC_HI:DCF_OPC_LO]]);
    held_words[held_n] = word;
    held_n++;
    if (held_n >= need_len) begin
      opc = held_words[0][DCF_OPC_HI:DCF_OPC_LO];
      is_sync = (opc == sync_opc);
      r = '0;
      r.kind = DCF_KIND_WORD;
      r.sync = is_sync;
      if (opc >= DCF_MIN_FWD_OPCODE) begin
        for (int i = 0; i < held_n; i++) begin
          r.word = held_words[i];
          run.push_back(r);
        end
        cmds_forwarded++;
      end else if (is_sync) begin
        // a sync below the forwarding floor still signals, with an empty word
        r.word = '0;
        run.push_back(r);
      end
      if (is_sync) begin
        busy_flag = 1'b0;
        sync_cmds++;
      end
      held_n = 0;
      need_len = 0;
    end
    if (eob) begin
      r = '0;
      r.kind = DCF_KIND_STATUS;
      r.ready = (held_n == 0);
      run.push_back(r);
      batch_open = 1'b0;
      status_count++;
    end
    // busy is the value after the step; last marks the end of this word's run
    foreach (run[i]) begin
      run[i].busy = busy_flag;
      run[i].last = (i == run.size() - 1);
      expected_results.push_back(run[i]);
    end
  endtask

  // offer one word, after a random gap when tx idling is on, and hold it until the block takes it
  task automatic send_word(input logic [63:0] word, input logic eob);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 12) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    cmd_word     <= word;
    end_of_batch <= eob;
    do @(posedge clk); while (in_stall);
    frame_word(word, eob);
    words_sent++;
  endtask

  // whole command of the table length; eob on the last word and/or at random
  task automatic send_command(input logic [DCF_OPC_W-1:0] opc, input bit eob_last,
                              input int eob_one_in);
    int n;
    logic [63:0] w;
    logic eob;
    n = int'(cmd_words_of[opc]);
    for (int i = 0; i < n; i++) begin
      w = random_word();
      if (i == 0) w = with_opcode(w, opc);
      eob = (eob_last && i == n - 1) ||
            (eob_one_in > 0 && $urandom_range(1, eob_one_in) == 1);
      send_word(w, eob);
    end
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // block is idle once every owed result is out and the pipeline has settled
  task automatic wait_idle();
    release_input();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write: setup cycle then access cycle; upper data bits are don't-care
  task automatic write_sync_opcode(input logic [DCF_OPC_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= SYNC_OPCODE_ADDR;
    pwdata  <= ($urandom << DCF_OPC_W) | 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sync_opc = value;
    sync_writes++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // checker: every accepted output transaction against the oldest expectation
  always @(posedge clk) begin : check_result
    dcf_result_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      rx_wait = rx_idle_on ? $urandom_range(0, 12) : 0;
      if (expected_results.size() == 0) begin
        report_mismatch("transaction with nothing pending", out_word, '0);
      end else begin
        want = expected_results.pop_front();
        if (kind !== want.kind) report_mismatch("kind", 64'(kind), 64'(want.kind));
        if (out_word !== want.word) report_mismatch("out_word", out_word, want.word);
        if (last_of_run !== want.last)
          report_mismatch("last_of_run", 64'(last_of_run), 64'(want.last));
        if (sync_interrupt !== want.sync)
          report_mismatch("sync_interrupt", 64'(sync_interrupt), 64'(want.sync));
        if (buffer_ready !== want.ready)
          report_mismatch("buffer_ready", 64'(buffer_ready), 64'(want.ready));
        if (pipe_busy !== want.busy)
          report_mismatch("pipe_busy", 64'(pipe_busy), 64'(want.busy));
      end
    end
  end

  // receiver: a long hold-off when a test asks for one, else the drawn wait
  always @(negedge clk) begin
    if (long_hold > 0) begin
      out_stall <= 1'b1;
      long_hold--;
    end else if (rx_wait > 0) begin
      out_stall <= 1'b1;
      rx_wait--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // extremes of the word, each kind of command, batch status both ways
  task automatic test_directed_frames();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    // all-zero word: opcode 0, dropped, no batch end so nothing comes out
    send_word('0, 1'b0);
    // all-ones word: opcode 63, single word, forwarded, then ready status
    send_word('1, 1'b1);
    // reset sync opcode as a one-word command closing the batch
    send_command(DCF_SYNC_OPCODE_RST, 1'b1, 0);
    // four-word command with no batch end in sight
    send_command(6'd8, 1'b0, 0);
    // batch ends mid-command: partial kept, finished in the next batch
    send_word(with_opcode(random_word(), 6'd36), 1'b1);
    send_word(random_word(), 1'b1);
    // low opcode that is not sync: dropped, status only
    send_word(with_opcode(random_word(), 6'd5), 1'b1);
    // six-word command ending the batch on its last word
    send_command(6'd9, 1'b1, 0);
    wait_idle();
  endtask

  // sync opcode moved around, including below the forwarding floor and the extremes
  task automatic test_sync_settings();
    write_sync_opcode(6'd3);
    // dropped sync: one empty word transaction with the interrupt
    send_word(with_opcode(random_word(), 6'd3), 1'b0);
    // the old sync opcode is now an ordinary command
    send_command(DCF_SYNC_OPCODE_RST, 1'b1, 0);
    send_command(6'd8, 1'b0, 0);
    wait_idle();
    write_sync_opcode(6'd0);
    send_word('0, 1'b1);
    wait_idle();
    write_sync_opcode(6'd63);
    send_word('1, 1'b1);
    wait_idle();
  endtask

  // mostly whole commands with random content; some stray words and odd batch ends
  task automatic test_random_stream(input int items_per_phase);
    logic [DCF_OPC_W-1:0] opc;
    int start;
    int r;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_sync_opcode(6'($urandom_range(8, 15)));  // long syncs, many results
        1: write_sync_opcode(6'($urandom_range(0, 7)));   // dropped syncs
        2: write_sync_opcode(6'($urandom_range(36, 37))); // two-word syncs
        default: write_sync_opcode(6'($urandom_range(0, 63)));
      endcase
      start = words_sent;
      tx_idle_on = 1'($urandom_range(0, 1));
      rx_idle_on = 1'($urandom_range(0, 1));
      while (words_sent - start < items_per_phase) begin
        // flip idling now and then so busy and quiet stretches both occur
        if ($urandom_range(0, 24) == 0) tx_idle_on = ~tx_idle_on;
        if ($urandom_range(0, 24) == 0) rx_idle_on = ~rx_idle_on;
        r = $urandom_range(0, 99);
        if (r < 15) begin
          send_word(random_word(), $urandom_range(0, 3) == 0);
        end else begin
          r = $urandom_range(0, 99);
          if (r < 40) opc = 6'($urandom_range(8, 15));
          else if (r < 55) opc = 6'($urandom_range(36, 37));
          else if (r < 70) opc = sync_opc;
          else opc = 6'($urandom_range(0, 63));
          send_command(opc, $urandom_range(0, 3) == 0, 6);
        end
      end
      // close any open command so the next register write meets a clean frame
      while (held_n != 0) send_word(random_word(), 1'b0);
      wait_idle();
    end
  endtask

  // receiver holds off for a long stretch while words keep coming back to back
  task automatic test_backpressure();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    long_hold = 250;
    send_command(6'd10, 1'b1, 0);
    for (int i = 0; i < 18; i++)
      send_word(with_opcode(random_word(), 6'd63), $urandom_range(0, 2) == 0);
    // then a long command with a shorter hold-off and the receiver idling at random
    rx_idle_on = 1'b1;
    long_hold = 120;
    send_command(6'd15, 1'b1, 0);
    wait_idle();
  endtask

  initial begin
    for (int i = 0; i < 64; i++) cmd_words_of[i] = 5'd1;
    cmd_words_of[8]  = 5'd4;
    cmd_words_of[9]  = 5'd6;
    cmd_words_of[10] = 5'd12;
    cmd_words_of[11] = 5'd14;
    cmd_words_of[12] = 5'd12;
    cmd_words_of[13] = 5'd14;
    cmd_words_of[14] = 5'd20;
    cmd_words_of[15] = 5'd22;
    cmd_words_of[36] = 5'd2;
    cmd_words_of[37] = 5'd2;

    held_n = 0;
    need_len = 0;
    busy_flag = 1'b0;
    batch_open = 1'b0;
    sync_opc = DCF_SYNC_OPCODE_RST;
    rx_wait = 0;
    long_hold = 0;

    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid     = 1'b0;
    cmd_word     = '0;
    end_of_batch = 1'b0;
    out_stall    = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_frames();
    test_sync_settings();
    test_random_stream(45);
    test_backpressure();

    if (expected_results.size() != 0)
      report_mismatch("transactions never delivered", 64'(expected_results.size()), '0);
    $display("covered %0d command words, %0d output transactions checked",
             words_sent, results_seen);
    $display("%0d commands forwarded, %0d syncs, %0d batch ends, %0d sync opcode writes",
             cmds_forwarded, sync_cmds, status_count, sync_writes);
    if (error_count == 0) begin
      $display("display_command_framer_core_tb: clean");
    end else begin
      $display("display_command_framer_core_tb: errors");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #3_000_000;
    $display("display_command_framer_core_tb: errors");
    $finish;
  end

endmodule
